// ----- rtl/mce_pkg.sv -----
// ----------------------------------------------------------------------------
// mce_pkg
// Shared constants, codes and handshake structs of the MOV/CLR executor.
// ----------------------------------------------------------------------------
`default_nettype none
package mce_pkg;

    localparam int MEMORY_WORDS = 32768;
    localparam int MEM_AW       = $clog2(MEMORY_WORDS);

    localparam logic [2:0] FN_LOAD = 3'd0;
    localparam logic [2:0] FN_STEP = 3'd1;
    localparam logic [2:0] FN_READ = 3'd2;
    localparam logic [2:0] FN_RREG = 3'd3;
    localparam logic [2:0] FN_INIT = 3'd4;

    localparam logic [1:0] K_READ   = 2'd0;
    localparam logic [1:0] K_WRITE  = 2'd1;
    localparam logic [1:0] K_FETCH  = 2'd2;
    localparam logic [1:0] K_REPORT = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_ODD     = 3'd3;
    localparam logic [2:0] ST_UNSUP   = 3'd4;

    localparam logic [15:0] OP_HALT   = 16'o0000000;
    localparam logic [9:0]  OP_CLR_HI = 10'o0050;
    localparam logic [3:0]  OP_MOV_HI = 4'd1;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [15:0] data;
    } trace_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] addr;
        logic [15:0] data;
        logic [2:0]  status;
    } report_t;

    function automatic logic pc_mode_bad(input logic [2:0] mode, input logic [2:0] r);
        return (r == 3'd7) && (mode == 3'd2 || mode == 3'd3 || mode == 3'd6 || mode == 3'd7);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/minicomputer_mov_clr_executor.sv -----
// ----------------------------------------------------------------------------
// minicomputer_mov_clr_executor
// Small word-memory CPU running HALT, CLR and word MOV, with a bus trace.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every item ends with
// a report result (access_kind report, last high); a step first gives one
// trace result per bus access, in order. Results appear one per cycle under
// strobe and cannot be held off. pc_value and the flags show the state after
// the item on all of its results.
// A load, register read, init or unknown func is reported straight from
// idle; a memory read goes through a bus read first. A step runs through
// the sequencer, one memory access or address or decode stage at a time,
// then hands its report and trace to the output buffer, which plays out the
// results. All words come through the single port of the main memory,
// one access at a time. busy drops after the report; the next item can be
// taken as soon as busy is low.
// After reset the block clears the whole memory (MEMORY_WORDS, 32768 words),
// one word a cycle, with busy high; boot PC writes are taken at any time and
// the block must be idle for them to matter.
// ----------------------------------------------------------------------------
`default_nettype none
module minicomputer_mov_clr_executor import mce_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  func,
    input  wire logic [15:0] address,
    input  wire logic [15:0] data,
    input  wire logic [2:0]  reg_index,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    output logic             strobe,
    output logic [1:0]       access_kind,
    output logic [15:0]      access_address,
    output logic [15:0]      read_data,
    output logic [2:0]       status,
    output logic [15:0]      pc_value,
    output logic             flag_n,
    output logic             flag_z,
    output logic             flag_v,
    output logic             flag_c,
    output logic             last
);

    logic              ram_we;
    logic [MEM_AW-1:0] ram_addr;
    logic [15:0]       ram_wdata;
    logic [15:0]       ram_q;
    trace_t            push;
    report_t           fin;
    logic              q_active;
    logic [3:0]        flags;

    mce_ram #(
        .WIDTH (16),
        .DEPTH (MEMORY_WORDS)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_q)
    );

    mce_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (func),
        .address   (address),
        .data      (data),
        .reg_index (reg_index),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .hold      (q_active),
        .busy      (busy),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_q     (ram_q),
        .push      (push),
        .fin       (fin),
        .pc        (pc_value),
        .flags     (flags)
    );

    mce_outq u_outq (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .fin            (fin),
        .active         (q_active),
        .strobe         (strobe),
        .access_kind    (access_kind),
        .access_address (access_address),
        .read_data      (read_data),
        .status         (status),
        .last           (last)
    );

    assign flag_n = flags[3];
    assign flag_z = flags[2];
    assign flag_v = flags[1];
    assign flag_c = flags[0];

endmodule
`default_nettype wire

// ----- rtl/mce_ram.sv -----
// ----------------------------------------------------------------------------
// mce_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module mce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ----- rtl/mce_core.sv -----
// ----------------------------------------------------------------------------
// mce_core
// Sequencer: registers, flags, memory clearing and the step micro-sequence.
// ----------------------------------------------------------------------------
`default_nettype none
module mce_core import mce_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [2:0]        func,
    input  wire logic [15:0]       address,
    input  wire logic [15:0]       data,
    input  wire logic [2:0]        reg_index,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_wdata,
    input  wire logic              hold,
    output logic                   busy,
    output logic                   ram_we,
    output logic [MEM_AW-1:0]      ram_addr,
    output logic [15:0]            ram_wdata,
    input  wire logic [15:0]       ram_q,
    output trace_t                 push,
    output report_t                fin,
    output logic [15:0]            pc,
    output logic [3:0]             flags
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_BRD, S_BRW, S_EA, S_ADDR, S_DST, S_BWR
    } state_t;

    typedef enum logic [2:0] {
        P_RDF, P_FETCH, P_IND, P_INDEX, P_OPER
    } purp_t;

    state_t            state_reg;
    purp_t             purp_reg;
    logic [15:0]       gpr_reg [8];
    logic [3:0]        flags_reg;
    logic [15:0]       boot_pc_reg;
    logic [15:0]       pc0_reg;
    logic [15:0]       instr_reg;
    logic [15:0]       ba_reg;
    logic [1:0]        kind_reg;
    logic              dst_reg;
    logic              mov_reg;
    logic [15:0]       v_reg;
    logic [MEM_AW-1:0] clr_reg;
    report_t           fin_reg;

    logic [2:0]  op_m;
    logic [2:0]  op_r;
    logic [15:0] rv;
    logic [15:0] rd;
    logic        ba_in;
    logic        ad_in;

    assign op_m  = dst_reg ? instr_reg[5:3] : instr_reg[11:9];
    assign op_r  = dst_reg ? instr_reg[2:0] : instr_reg[8:6];
    assign rv    = gpr_reg[op_r];
    assign ba_in = 17'(ba_reg[15:1]) < 17'(MEMORY_WORDS);
    assign ad_in = 17'(address[15:1]) < 17'(MEMORY_WORDS);
    assign rd    = ba_in ? ram_q : 16'd0;

    assign busy  = (state_reg != S_IDLE) || fin_reg.valid || hold;
    assign pc    = gpr_reg[7];
    assign flags = flags_reg;
    assign fin   = fin_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = ba_reg[MEM_AW:1];
        ram_wdata = v_reg;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg;
            ram_wdata = 16'd0;
        end
        else if (state_reg == S_IDLE)
        begin
            ram_addr  = address[MEM_AW:1];
            ram_wdata = data;
            ram_we    = start && !busy && (func == FN_LOAD) && !address[0] && ad_in;
        end
        else if (state_reg == S_BWR)
        begin
            ram_we = !ba_reg[0] && ba_in;
        end
    end

    always_comb
    begin
        push.valid = 1'b0;
        push.kind  = kind_reg;
        push.addr  = ba_reg;
        push.data  = rd;
        if (state_reg == S_BRW)
        begin
            push.valid = (purp_reg != P_RDF);
        end
        else if (state_reg == S_BWR)
        begin
            push.valid = !ba_reg[0];
            push.kind  = K_WRITE;
            push.data  = v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            gpr_reg       <= '{default: 16'd0};
            flags_reg     <= 4'd0;
            boot_pc_reg   <= 16'd0;
            fin_reg.valid <= 1'b0;
        end
        else
        begin
            fin_reg.valid <= 1'b0;
            if (cfg_we)
            begin
                boot_pc_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == MEM_AW'(MEMORY_WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    instr_reg <= 16'd0;
                    dst_reg   <= 1'b0;
                    kind_reg  <= K_READ;
                    if (start && !busy)
                    begin
                        unique case (func)
                            FN_LOAD:
                            begin
                                fin_reg <= '{1'b1, address, data,
                                             address[0] ? ST_ODD : ST_OK};
                            end
                            FN_STEP:
                            begin
                                pc0_reg   <= gpr_reg[7];
                                ba_reg    <= gpr_reg[7];
                                kind_reg  <= K_FETCH;
                                purp_reg  <= P_FETCH;
                                state_reg <= S_BRD;
                            end
                            FN_READ:
                            begin
                                ba_reg    <= address;
                                purp_reg  <= P_RDF;
                                state_reg <= S_BRD;
                            end
                            FN_RREG:
                            begin
                                fin_reg <= '{1'b1, 16'd0, gpr_reg[reg_index], ST_OK};
                            end
                            FN_INIT:
                            begin
                                gpr_reg    <= '{default: 16'd0};
                                gpr_reg[7] <= boot_pc_reg;
                                flags_reg  <= 4'd0;
                                fin_reg    <= '{1'b1, 16'd0, 16'd0, ST_OK};
                            end
                            default:
                            begin
                                fin_reg <= '{1'b1, 16'd0, 16'd0, ST_INVALID};
                            end
                        endcase
                    end
                end
                S_BRD:
                begin
                    if (ba_reg[0])
                    begin
                        fin_reg   <= '{1'b1, ba_reg, instr_reg, ST_ODD};
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_BRW;
                    end
                end
                S_BRW:
                begin
                    kind_reg <= K_READ;
                    unique case (purp_reg)
                        P_RDF:
                        begin
                            fin_reg   <= '{1'b1, ba_reg, rd, ST_OK};
                            state_reg <= S_IDLE;
                        end
                        P_FETCH:
                        begin
                            instr_reg  <= rd;
                            gpr_reg[7] <= pc0_reg + 16'd2;
                            state_reg  <= S_IDLE;
                            if (rd == OP_HALT)
                            begin
                                fin_reg <= '{1'b1, pc0_reg, rd, ST_HALT};
                            end
                            else if (rd[15:6] == OP_CLR_HI)
                            begin
                                if (pc_mode_bad(rd[5:3], rd[2:0]))
                                begin
                                    fin_reg <= '{1'b1, pc0_reg, rd, ST_UNSUP};
                                end
                                else if (rd[5:3] == 3'd0)
                                begin
                                    // Written after the PC advance so CLR R7 wins.
                                    gpr_reg[rd[2:0]] <= 16'd0;
                                    flags_reg        <= 4'b0100;
                                    fin_reg          <= '{1'b1, pc0_reg, rd, ST_OK};
                                end
                                else
                                begin
                                    mov_reg   <= 1'b0;
                                    v_reg     <= 16'd0;
                                    dst_reg   <= 1'b1;
                                    state_reg <= S_EA;
                                end
                            end
                            else if (rd[15:12] == OP_MOV_HI)
                            begin
                                mov_reg <= 1'b1;
                                if (pc_mode_bad(rd[11:9], rd[8:6]) ||
                                    pc_mode_bad(rd[5:3], rd[2:0]))
                                begin
                                    fin_reg <= '{1'b1, pc0_reg, rd, ST_UNSUP};
                                end
                                else if (rd[11:9] == 3'd0)
                                begin
                                    // A source of R7 sees the PC already advanced.
                                    v_reg     <= (rd[8:6] == 3'd7) ? pc0_reg + 16'd2
                                                                   : gpr_reg[rd[8:6]];
                                    state_reg <= S_DST;
                                end
                                else
                                begin
                                    state_reg <= S_EA;
                                end
                            end
                            else
                            begin
                                fin_reg <= '{1'b1, pc0_reg, rd, ST_INVALID};
                            end
                        end
                        P_IND:
                        begin
                            ba_reg    <= rd;
                            state_reg <= S_ADDR;
                        end
                        P_INDEX:
                        begin
                            gpr_reg[7] <= gpr_reg[7] + 16'd2;
                            ba_reg     <= rv + rd;
                            if (op_m == 3'd6)
                            begin
                                state_reg <= S_ADDR;
                            end
                            else
                            begin
                                purp_reg  <= P_IND;
                                state_reg <= S_BRD;
                            end
                        end
                        P_OPER:
                        begin
                            v_reg     <= rd;
                            state_reg <= S_DST;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_EA:
                begin
                    case (op_m)
                        3'd1:
                        begin
                            ba_reg    <= rv;
                            state_reg <= S_ADDR;
                        end
                        3'd2:
                        begin
                            ba_reg        <= rv;
                            gpr_reg[op_r] <= rv + 16'd2;
                            state_reg     <= S_ADDR;
                        end
                        3'd3:
                        begin
                            ba_reg        <= rv;
                            gpr_reg[op_r] <= rv + 16'd2;
                            purp_reg      <= P_IND;
                            state_reg     <= S_BRD;
                        end
                        3'd4:
                        begin
                            ba_reg        <= rv - 16'd2;
                            gpr_reg[op_r] <= rv - 16'd2;
                            state_reg     <= S_ADDR;
                        end
                        3'd5:
                        begin
                            ba_reg        <= rv - 16'd2;
                            gpr_reg[op_r] <= rv - 16'd2;
                            purp_reg      <= P_IND;
                            state_reg     <= S_BRD;
                        end
                        3'd6, 3'd7:
                        begin
                            ba_reg    <= gpr_reg[7];
                            purp_reg  <= P_INDEX;
                            state_reg <= S_BRD;
                        end
                        default:
                        begin
                            ba_reg    <= 16'd0;
                            state_reg <= S_ADDR;
                        end
                    endcase
                end
                S_ADDR:
                begin
                    if (!dst_reg)
                    begin
                        purp_reg  <= P_OPER;
                        state_reg <= S_BRD;
                    end
                    else
                    begin
                        state_reg <= S_BWR;
                    end
                end
                S_DST:
                begin
                    if (instr_reg[5:3] == 3'd0)
                    begin
                        gpr_reg[instr_reg[2:0]] <= v_reg;
                        flags_reg <= {v_reg[15], v_reg == 16'd0, 1'b0, flags_reg[0]};
                        fin_reg   <= '{1'b1, pc0_reg, instr_reg, ST_OK};
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        dst_reg   <= 1'b1;
                        state_reg <= S_EA;
                    end
                end
                S_BWR:
                begin
                    state_reg <= S_IDLE;
                    if (ba_reg[0])
                    begin
                        fin_reg <= '{1'b1, ba_reg, instr_reg, ST_ODD};
                    end
                    else
                    begin
                        flags_reg <= mov_reg ? {v_reg[15], v_reg == 16'd0, 1'b0, flags_reg[0]}
                                             : 4'b0100;
                        fin_reg   <= '{1'b1, pc0_reg, instr_reg, ST_OK};
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mce_outq.sv -----
// ----------------------------------------------------------------------------
// mce_outq
// Trace buffer: holds an item's bus accesses and plays them out with its report.
// ----------------------------------------------------------------------------
`default_nettype none
module mce_outq import mce_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire trace_t      push,
    input  wire report_t     fin,
    output logic             active,
    output logic             strobe,
    output logic [1:0]       access_kind,
    output logic [15:0]      access_address,
    output logic [15:0]      read_data,
    output logic [2:0]       status,
    output logic             last
);

    trace_t      buf_reg [8];
    logic [2:0]  cnt_reg;
    logic [2:0]  rptr_reg;
    logic        active_reg;
    report_t     rep_reg;
    logic        at_rep;

    assign active = active_reg;
    assign strobe = active_reg;
    assign at_rep = (rptr_reg == cnt_reg);

    always_comb
    begin
        if (at_rep)
        begin
            access_kind    = K_REPORT;
            access_address = rep_reg.addr;
            read_data      = rep_reg.data;
            status         = rep_reg.status;
        end
        else
        begin
            access_kind    = buf_reg[rptr_reg].kind;
            access_address = buf_reg[rptr_reg].addr;
            read_data      = buf_reg[rptr_reg].data;
            status         = ST_OK;
        end
        last = active_reg && at_rep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 3'd0;
            rptr_reg   <= 3'd0;
            active_reg <= 1'b0;
        end
        else
        begin
            if (push.valid)
            begin
                buf_reg[cnt_reg] <= push;
                cnt_reg          <= cnt_reg + 3'd1;
            end
            if (fin.valid)
            begin
                rep_reg    <= fin;
                rptr_reg   <= 3'd0;
                active_reg <= 1'b1;
            end
            else if (active_reg)
            begin
                if (at_rep)
                begin
                    active_reg <= 1'b0;
                    cnt_reg    <= 3'd0;
                end
                else
                begin
                    rptr_reg <= rptr_reg + 3'd1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mce_checker.sv -----
// ----------------------------------------------------------------------------
// mce_checker
// Port-level checks of the executor's result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none
module mce_checker import mce_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic       strobe,
    input  wire logic [1:0] access_kind,
    input  wire logic [2:0] status,
    input  wire logic       last
);

    // An accepted item keeps the block busy until its report is out.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low right after an accepted item");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result shown while not busy");

    // Trace results of one item come back to back and end in the report.
    a_trace_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside an item's results");

    a_last_report: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (last == (access_kind == K_REPORT)))
        else $error("last does not mark the report");

    a_trace_status: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> status == ST_OK)
        else $error("trace result with nonzero status");

endmodule

bind minicomputer_mov_clr_executor mce_checker u_mce_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .strobe      (strobe),
    .access_kind (access_kind),
    .status      (status),
    .last        (last)
);
`default_nettype wire
